/* sv/track_record_delta_expander_core_assert.svh */
// Assertion macros shared by the track record expander RTL.
`ifndef TRACK_RECORD_DELTA_EXPANDER_CORE_ASSERT_SVH
`define TRACK_RECORD_DELTA_EXPANDER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check, idle while reset is asserted.
`define TRDE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds through reset.
`define TRDE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TRDE_ASSERT(lbl, prop, msg)
`define TRDE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* sv/trde_pkg.sv */
// Types and constants of the track record expander.
package trde_pkg;

    typedef logic [23:0][7:0] buf_t;
    typedef logic [3:0][7:0]  depth_t;

    typedef struct packed {
        logic [7:0]  size_flags;
        logic [63:0] payload_low;
        logic [63:0] payload_mid;
        logic [63:0] payload_high;
    } in_req_t;

    typedef struct packed {
        logic        is_header;
        logic [7:0]  record_length;
        logic [63:0] record_low;
        logic [63:0] record_mid;
        logic [63:0] record_high;
    } out_req_t;

    localparam logic [6:0] HDR_LIMIT      = 7'h14;
    localparam logic [6:0] SHORT_MAX      = 7'h05;
    localparam logic [4:0] U_SHORT        = 5'h0C;
    localparam logic [4:0] U_LONG         = 5'h14;
    localparam logic [7:0] PAD_LENGTH     = 8'h18;

    // Size codes with special handling
    localparam logic [6:0] SZ_XOR_SHORT   = 7'd3;
    localparam logic [6:0] SZ_DIFF_SHORT  = 7'd5;
    localparam logic [6:0] SZ_XOR_MID     = 7'd6;
    localparam logic [6:0] SZ_XOR_LONG    = 7'd7;
    localparam logic [6:0] SZ_DIFF_MID    = 7'd8;
    localparam logic [6:0] SZ_DIFF_LONG   = 7'd9;
    localparam logic [6:0] SZ_FILL_NOTIME = 7'd10;
    localparam logic [6:0] SZ_FILL        = 7'd14;
    localparam logic [6:0] SZ_PAD_DEPTH   = 7'd16;

    // Invalid depth, lowest byte first: 51 59 04 69
    localparam depth_t DEPTH_INVALID = {8'h69, 8'h04, 8'h59, 8'h51};

endpackage

/* sv/trde_expand.sv */
// Combinational expansion of one compact record against the kept record.
module trde_expand (
    input  trde_pkg::in_req_t  item,
    input  trde_pkg::buf_t     prev,
    output trde_pkg::out_req_t result
);

    trde_pkg::buf_t q;
    trde_pkg::buf_t b;
    logic [6:0]     sz;
    logic [4:0]     u;
    logic [7:0]     len;
    logic           hdr;

    always_comb
    begin
        q   = {item.payload_high, item.payload_mid, item.payload_low};
        b   = prev;
        sz  = item.size_flags[6:0];
        hdr = (sz > trde_pkg::HDR_LIMIT);
        u   = trde_pkg::U_SHORT;
        len = item.size_flags;
        if (hdr)
        begin
            // header: copy raw-byte count, capped by buffer size
            for (int k = 0; k < 24; k++)
            begin
                if (8'(k) < item.size_flags)
                begin
                    b[k] = q[k];
                end
            end
        end
        else
        begin
            u = (sz <= trde_pkg::SHORT_MAX) ? trde_pkg::U_SHORT : trde_pkg::U_LONG;
            case (sz)
                trde_pkg::SZ_FILL_NOTIME, trde_pkg::SZ_FILL:
                begin
                    if (sz == trde_pkg::SZ_FILL_NOTIME)
                    begin
                        q[13:10] = '1;
                    end
                    b[19:16] = trde_pkg::DEPTH_INVALID;
                    b[15:12] = q[9:6];
                    b[11:8]  = q[13:10];
                    b[7:5]   = q[5:3];
                    b[4]     = 8'h00;
                    b[3:1]   = q[2:0];
                    b[0]     = 8'h00;
                end
                trde_pkg::SZ_XOR_SHORT, trde_pkg::SZ_XOR_MID, trde_pkg::SZ_XOR_LONG:
                begin
                    if (sz == trde_pkg::SZ_XOR_LONG)
                    begin
                        b[15] ^= q[6];
                    end
                    if (sz != trde_pkg::SZ_XOR_SHORT)
                    begin
                        b[14] ^= q[5];
                        b[13] ^= q[4];
                        b[12] ^= q[3];
                    end
                    b[8] ^= q[2];
                    b[5] ^= q[1];
                    b[4]  = 8'h00;
                    b[1] ^= q[0];
                    b[0]  = 8'h00;
                end
                trde_pkg::SZ_DIFF_SHORT, trde_pkg::SZ_DIFF_MID, trde_pkg::SZ_DIFF_LONG:
                begin
                    if (sz == trde_pkg::SZ_DIFF_LONG)
                    begin
                        b[15] ^= q[8];
                    end
                    if (sz != trde_pkg::SZ_DIFF_SHORT)
                    begin
                        b[14] ^= q[7];
                        b[13] ^= q[6];
                        b[12] ^= q[5];
                    end
                    b[8] ^= q[4];
                    b[5] ^= q[3];
                    b[4] ^= q[2];
                    b[1] ^= q[1];
                    b[0] ^= q[0];
                end
                trde_pkg::SZ_PAD_DEPTH:
                begin
                    b[15:0]  = q[15:0];
                    b[19:16] = trde_pkg::DEPTH_INVALID;
                    u        = trde_pkg::U_LONG;
                end
                default:
                begin
                    u = sz[4:0];
                    for (int k = 0; k < 24; k++)
                    begin
                        if (7'(k) < sz)
                        begin
                            b[k] = q[k];
                        end
                    end
                end
            endcase
            // append segment flag right after the copied bytes
            for (int k = 0; k < 24; k++)
            begin
                if (5'(k) == u)
                begin
                    b[k] = {7'd0, item.size_flags[7]};
                end
            end
            len = {3'd0, u} + 8'd1;
            if (u == trde_pkg::U_LONG)
            begin
                b[23:21] = '1;
                len      = trde_pkg::PAD_LENGTH;
            end
        end
        result.is_header     = hdr;
        result.record_length = len;
        result.record_low    = b[7:0];
        result.record_mid    = b[15:8];
        result.record_high   = b[23:16];
    end

endmodule

/* sv/track_record_delta_expander_core.sv */
// Path: an accepted request is held in the input register, then its expansion is registered in the result register.
// Throughput: one request per clock while the result is not stalled; the expansion is a single byte-mux/XOR level.
// A stalled result backs up into the input register, then stalls the source.
// Reset: both valids drop and the kept 24-byte record clears to zero.
`include "track_record_delta_expander_core_assert.svh"

module track_record_delta_expander_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  trde_pkg::in_req_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output trde_pkg::out_req_t result
);

    logic               stage_valid_reg;
    logic               stage_valid_next;
    trde_pkg::in_req_t  stage_reg;
    logic               result_valid_reg;
    logic               result_valid_next;
    trde_pkg::out_req_t result_reg;
    trde_pkg::buf_t     kept_reg;
    trde_pkg::out_req_t calc;
    logic               fire;
    logic               take;

    trde_expand u_expand (
        .item   (stage_reg),
        .prev   (kept_reg),
        .result (calc)
    );

    assign fire       = stage_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = stage_valid_reg && !fire;
    assign take       = item_valid && !item_stall;

    always_comb
    begin
        stage_valid_next  = take || (stage_valid_reg && !fire);
        result_valid_next = fire || (result_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            kept_reg         <= '0;
        end
        else
        begin
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
            if (fire)
            begin
                kept_reg <= {calc.record_high, calc.record_mid, calc.record_low};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_reg <= item;
        end
        if (fire)
        begin
            result_reg <= calc;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `TRDE_ASSERT(a_hdr_size, result_valid && result.is_header |-> result.record_length[6:0] > trde_pkg::HDR_LIMIT, "header with point size")
    `TRDE_ASSERT(a_no_len21, result_valid && !result.is_header |-> result.record_length != 8'd21, "point length 21 not padded")
    `TRDE_ASSERT(a_pad_ff, result_valid && !result.is_header && result.record_length == trde_pkg::PAD_LENGTH |-> result.record_high[63:40] == 24'hffffff, "pad bytes not 0xff")
    `TRDE_ASSERT(a_rise_src, $rose(result_valid) |-> $past(stage_valid_reg), "result without staged request")
    `TRDE_ASSERT_ALWAYS(a_stall_src, item_stall |-> stage_valid_reg, "stall with empty input register")

endmodule
